@@ sv/sndp_pkg.sv @@
package sndp_pkg;

  // Default storage widths of the accumulators
  localparam int MantBitsDef = 64;
  localparam int ExpBitsDef  = 16;

  // Fixed widths of the item fields
  localparam int CharW = 8;
  localparam int MantW = 64;
  localparam int ExpW  = 16;
  localparam int AccW  = 32;

  // Characters of the number grammar
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharDot   = 8'h2e;
  localparam logic [CharW-1:0] CharE     = 8'h65;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;
  localparam logic [CharW-1:0] CharPlus  = 8'h2b;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusNoLead = 2'd1,
    StatusNoExp  = 2'd2
  } status_e;

  // Parse position, one-hot
  typedef enum logic [7:0] {
    PhStart         = 8'b0000_0001,
    PhAfterSign     = 8'b0000_0010,
    PhAfterLead     = 8'b0000_0100,
    PhFraction      = 8'b0000_1000,
    PhExpStart      = 8'b0001_0000,
    PhExpAfterSign  = 8'b0010_0000,
    PhExpDigits     = 8'b0100_0000,
    PhDone          = 8'b1000_0000
  } phase_e;

  // How the parse ended, which decides the result fields
  typedef enum logic [1:0] {
    EndOk        = 2'd0,
    EndNoLead    = 2'd1,
    EndNoExp     = 2'd2,
    EndExpDigits = 2'd3
  } end_kind_e;

  // Classify the phase in which the parse stops
  function automatic end_kind_e kind_of(input phase_e ph);
    end_kind_e k;
    case (ph)
      PhStart, PhAfterSign:       k = EndNoLead;
      PhExpStart, PhExpAfterSign: k = EndNoExp;
      PhExpDigits:                k = EndExpDigits;
      default:                    k = EndOk;
    endcase
    return k;
  endfunction

endpackage

@@ sv/sci_notation_decimal_parser_core.sv @@
// Decimal scientific-notation parser. Characters arrive one per item on the
// input channel, with last_char_i set on the final one; the block takes one
// character every cycle unless in_stall_o is set. Each character updates the
// parse state (one multiply-by-ten-and-add on the mantissa or the exponent
// digits); a final character also copies the state into a finish register,
// where the exponent is combined and the status is decided. The result is
// then loaded into the output register once that register is empty or taken.
// Input stalls only while both the finish register and the output register
// are full and the output is stalled. MANT_BITS sets the width at which the
// mantissa wraps and EXP_BITS the width at which the exponent wraps;
// overflow_o reports any wrap.
module sci_notation_decimal_parser_core #(
  parameter int MANT_BITS = sndp_pkg::MantBitsDef,
  parameter int EXP_BITS  = sndp_pkg::ExpBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sndp_pkg::CharW-1:0]    char_code_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          negative_o,
  output logic [sndp_pkg::MantW-1:0]    mantissa_o,
  output logic signed [sndp_pkg::ExpW-1:0] exponent_o,
  output logic [1:0]                    status_o,
  output logic                          overflow_o
);

  localparam int MW = MANT_BITS;
  localparam int EW = EXP_BITS;
  localparam int AW = sndp_pkg::AccW;
  localparam int XW = AW + 4;   // room for acc * 10 + digit
  localparam int SW = AW + 2;   // room for exponent sum

  // Parse state
  sndp_pkg::phase_e    phase_q, phase_d;
  sndp_pkg::end_kind_e done_kind_q, done_kind_d;
  logic                sign_q, sign_d;
  logic [MW-1:0]       mant_q, mant_d;
  logic signed [EW-1:0] fexp_q, fexp_d;
  logic [AW-1:0]       eacc_q, eacc_d;
  logic                eneg_q, eneg_d;
  logic                wrap_q, wrap_d;
  sndp_pkg::end_kind_e end_kind;

  // Finish register
  logic                pb_valid_q;
  logic                pb_sign_q;
  logic [MW-1:0]       pb_mant_q;
  logic signed [EW-1:0] pb_fexp_q;
  logic [AW-1:0]       pb_eacc_q;
  logic                pb_eneg_q;
  logic                pb_wrap_q;
  sndp_pkg::end_kind_e pb_kind_q;

  // Output register
  logic                out_valid_q;
  logic                out_neg_q;
  logic [sndp_pkg::MantW-1:0] out_mant_q;
  logic [sndp_pkg::ExpW-1:0]  out_exp_q;
  sndp_pkg::status_e   out_status_q;
  logic                out_ovf_q;

  logic in_acc, out_load;
  logic is_dig, is_minus, is_plus, is_dot, is_e;
  logic [3:0] dig_val;
  logic [MW+3:0] mant_x10;
  logic mant_ovf;
  logic fexp_ovf;
  logic [XW-1:0] eacc_ext, eacc_x10;
  logic eacc_ovf;

  // Handshake: stall only when both result stages are held
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pb_valid_q && !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Character classes
  assign is_dig   = char_code_i inside {[sndp_pkg::CharZero:sndp_pkg::CharNine]};
  assign is_minus = char_code_i == sndp_pkg::CharMinus;
  assign is_plus  = char_code_i == sndp_pkg::CharPlus;
  assign is_dot   = char_code_i == sndp_pkg::CharDot;
  assign is_e     = char_code_i == sndp_pkg::CharE;
  assign dig_val  = 4'(char_code_i - sndp_pkg::CharZero);

  // Mantissa times ten plus digit, with carry-out as wrap
  assign mant_x10 = ({4'b0, mant_q} << 3) + ({4'b0, mant_q} << 1) + (MW+4)'(dig_val);
  assign mant_ovf = |mant_x10[MW+3:MW];

  // Fraction exponent wraps when decremented from its minimum
  assign fexp_ovf = fexp_q == {1'b1, {(EW-1){1'b0}}};

  // Signed exponent digits times ten plus digit
  assign eacc_ext = {{4{eacc_q[AW-1]}}, eacc_q};
  assign eacc_x10 = (eacc_ext << 3) + (eacc_ext << 1) + XW'(dig_val);
  assign eacc_ovf = !((eacc_x10[XW-1:AW-1] == '0) || (eacc_x10[XW-1:AW-1] == '1));

  // Advance the parse by one character
  always_comb begin
    phase_d     = phase_q;
    done_kind_d = done_kind_q;
    sign_d      = sign_q;
    mant_d      = mant_q;
    fexp_d      = fexp_q;
    eacc_d      = eacc_q;
    eneg_d      = eneg_q;
    wrap_d      = wrap_q;
    case (phase_q)
      sndp_pkg::PhStart: begin
        if (is_minus) begin
          sign_d  = 1'b1;
          phase_d = sndp_pkg::PhAfterSign;
        end else if (is_plus) begin
          phase_d = sndp_pkg::PhAfterSign;
        end else if (is_dig) begin
          mant_d  = MW'(dig_val);
          phase_d = sndp_pkg::PhAfterLead;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhAfterSign: begin
        if (is_dig) begin
          mant_d  = MW'(dig_val);
          phase_d = sndp_pkg::PhAfterLead;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhAfterLead: begin
        if (is_dot) begin
          phase_d = sndp_pkg::PhFraction;
        end else if (is_e) begin
          phase_d = sndp_pkg::PhExpStart;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhFraction: begin
        if (is_dig) begin
          mant_d = mant_x10[MW-1:0];
          fexp_d = fexp_q - 1'b1;
          wrap_d = wrap_q || mant_ovf || fexp_ovf;
        end else if (is_e) begin
          phase_d = sndp_pkg::PhExpStart;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhExpStart: begin
        if (is_minus) begin
          eneg_d  = 1'b1;
          phase_d = sndp_pkg::PhExpAfterSign;
        end else if (is_plus) begin
          phase_d = sndp_pkg::PhExpAfterSign;
        end else if (is_dig) begin
          eacc_d  = AW'(dig_val);
          phase_d = sndp_pkg::PhExpDigits;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhExpAfterSign: begin
        if (is_dig) begin
          eacc_d  = AW'(dig_val);
          phase_d = sndp_pkg::PhExpDigits;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      sndp_pkg::PhExpDigits: begin
        if (is_dig) begin
          eacc_d = eacc_x10[AW-1:0];
          wrap_d = wrap_q || eacc_ovf;
        end else begin
          phase_d = sndp_pkg::PhDone;
        end
      end
      default: begin
      end
    endcase
    // Remember where the parse stopped; later characters are ignored
    if (phase_q != sndp_pkg::PhDone && phase_d == sndp_pkg::PhDone) begin
      done_kind_d = sndp_pkg::kind_of(phase_q);
    end
  end

  assign end_kind = (phase_d == sndp_pkg::PhDone) ? done_kind_d : sndp_pkg::kind_of(phase_d);

  // Parse state: update per item, clear after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sndp_pkg::PhStart;
      done_kind_q <= sndp_pkg::EndOk;
      sign_q      <= 1'b0;
      mant_q      <= '0;
      fexp_q      <= '0;
      eacc_q      <= '0;
      eneg_q      <= 1'b0;
      wrap_q      <= 1'b0;
    end else if (in_acc) begin
      if (last_char_i) begin
        phase_q     <= sndp_pkg::PhStart;
        done_kind_q <= sndp_pkg::EndOk;
        sign_q      <= 1'b0;
        mant_q      <= '0;
        fexp_q      <= '0;
        eacc_q      <= '0;
        eneg_q      <= 1'b0;
        wrap_q      <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        done_kind_q <= done_kind_d;
        sign_q      <= sign_d;
        mant_q      <= mant_d;
        fexp_q      <= fexp_d;
        eacc_q      <= eacc_d;
        eneg_q      <= eneg_d;
        wrap_q      <= wrap_d;
      end
    end
  end

  // Finish register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_valid_q <= 1'b0;
    end else if (in_acc && last_char_i) begin
      pb_valid_q <= 1'b1;
    end else if (out_load) begin
      pb_valid_q <= 1'b0;
    end
  end

  // Finish register: capture the final parse state
  always_ff @(posedge clk_i) begin
    if (in_acc && last_char_i) begin
      pb_sign_q <= sign_d;
      pb_mant_q <= mant_d;
      pb_fexp_q <= fexp_d;
      pb_eacc_q <= eacc_d;
      pb_eneg_q <= eneg_d;
      pb_wrap_q <= wrap_d;
      pb_kind_q <= end_kind;
    end
  end

  // Combine fraction exponent and exponent digits
  logic [SW-1:0] fexp_ext, eacc_sext, exp_sum;
  logic exp_sum_ovf;
  logic signed [EW-1:0] fin_exp;
  logic [AW-1:0] fin_exp_ext;
  logic [MW-1:0] fin_mant;
  logic fin_ovf;
  sndp_pkg::status_e fin_status;

  assign fexp_ext    = SW'(pb_fexp_q);
  assign eacc_sext   = {{2{pb_eacc_q[AW-1]}}, pb_eacc_q};
  assign exp_sum     = pb_eneg_q ? (fexp_ext - eacc_sext) : (fexp_ext + eacc_sext);
  assign exp_sum_ovf = !((exp_sum[SW-1:EW-1] == '0) || (exp_sum[SW-1:EW-1] == '1));

  // Decide the result fields
  always_comb begin
    fin_mant   = pb_mant_q;
    fin_exp    = pb_fexp_q;
    fin_ovf    = pb_wrap_q;
    fin_status = sndp_pkg::StatusOk;
    case (pb_kind_q)
      sndp_pkg::EndNoLead: begin
        fin_mant   = '0;
        fin_exp    = '0;
        fin_ovf    = 1'b0;
        fin_status = sndp_pkg::StatusNoLead;
      end
      sndp_pkg::EndNoExp: begin
        fin_status = sndp_pkg::StatusNoExp;
      end
      sndp_pkg::EndExpDigits: begin
        fin_exp = exp_sum[EW-1:0];
        fin_ovf = pb_wrap_q || exp_sum_ovf;
      end
      default: begin
      end
    endcase
  end

  assign fin_exp_ext = AW'(fin_exp);

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= pb_valid_q;
    end
  end

  // Output register: hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (out_load && pb_valid_q) begin
      out_neg_q    <= pb_sign_q;
      out_mant_q   <= sndp_pkg::MantW'(fin_mant);
      out_exp_q    <= fin_exp_ext[sndp_pkg::ExpW-1:0];
      out_status_q <= fin_status;
      out_ovf_q    <= fin_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign negative_o  = out_neg_q;
  assign mantissa_o  = out_mant_q;
  assign exponent_o  = out_exp_q;
  assign status_o    = out_status_q;
  assign overflow_o  = out_ovf_q;

endmodule

@@ sv/sndp_checker.sv @@
module sndp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          last_char_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          negative_o,
  input logic [sndp_pkg::MantW-1:0]    mantissa_o,
  input logic signed [sndp_pkg::ExpW-1:0] exponent_o,
  input logic [1:0]                    status_o,
  input logic                          overflow_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mantissa_o) &&
      $stable(exponent_o) && $stable(status_o) && $stable(negative_o) &&
      $stable(overflow_o))
    else $error("stalled result changed");

  // Stall input only under output backpressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A new result follows a final character, through the finish and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_char_i, 2))
    else $error("result without a final character");

  // Drop numeric fields when no leading digit was found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sndp_pkg::StatusNoLead |->
      mantissa_o == '0 && exponent_o == '0 && !overflow_o)
    else $error("numeric fields set without a leading digit");

endmodule

bind sci_notation_decimal_parser_core sndp_checker u_sndp_checker (.*);

@@ verif/tb_sci_notation_decimal_parser_core.sv @@
module tb_sci_notation_decimal_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  // One character on the input channel, with its lead-in wait
  typedef struct {
    logic [sndp_pkg::CharW-1:0] code;
    logic                       last;
    int unsigned                gap;
    bit                         drain;
  } char_item_t;

  // One parsed number on the output channel
  typedef struct {
    logic                       negative;
    logic [sndp_pkg::MantW-1:0] mantissa;
    logic [sndp_pkg::ExpW-1:0]  exponent;
    sndp_pkg::status_e          status;
    logic                       overflow;
  } num_result_t;

  localparam logic [63:0] MantMask = (sndp_pkg::MantBitsDef == 64) ? '1 :
                                     ((64'd1 << sndp_pkg::MantBitsDef) - 1);
  localparam longint ExpLo   = -(longint'(1) <<< (sndp_pkg::ExpBitsDef - 1));
  localparam longint ExpHi   = (longint'(1) <<< (sndp_pkg::ExpBitsDef - 1)) - 1;
  localparam int     MaxWait = 12;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [sndp_pkg::CharW-1:0] char_code_i = '0;
  logic                       last_char_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       negative_o;
  logic [sndp_pkg::MantW-1:0] mantissa_o;
  logic signed [sndp_pkg::ExpW-1:0] exponent_o;
  logic [1:0]                 status_o;
  logic                       overflow_o;

  char_item_t  char_items[$];
  num_result_t expected_numbers[$];
  logic [sndp_pkg::CharW-1:0] txt[$];

  // Parser state mirrored from the block's behavior
  sndp_pkg::phase_e  ps_phase;
  bit                ps_neg;
  logic [63:0]       ps_mant;
  longint            ps_frac_exp;
  logic [31:0]       ps_exp_acc;
  bit                ps_exp_neg;
  bit                ps_wrap;
  sndp_pkg::status_e ps_status;

  // Driver and monitor bookkeeping
  char_item_t  cur;
  bit          drv_active = 1'b0;
  bit          gap_armed  = 1'b0;
  int unsigned gap_left   = 0;
  bit          in_taken   = 1'b0;
  int          gap_mode   = 1;
  int          out_mode   = 1;
  int unsigned stall_left = 0;
  int unsigned res_seen   = 0;
  int unsigned mismatch_cnt = 0;

  sci_notation_decimal_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .negative_o  (negative_o),
    .mantissa_o  (mantissa_o),
    .exponent_o  (exponent_o),
    .status_o    (status_o),
    .overflow_o  (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Clear the parser state for the next string
  function automatic void parse_reset();
    ps_phase    = sndp_pkg::PhStart;
    ps_neg      = 1'b0;
    ps_mant     = '0;
    ps_frac_exp = 0;
    ps_exp_acc  = '0;
    ps_exp_neg  = 1'b0;
    ps_wrap     = 1'b0;
    ps_status   = sndp_pkg::StatusOk;
  endfunction

  // Wrap an exponent into the EXP_BITS range, flagging any wrap
  function automatic longint exp_fit(longint v);
    longint span;
    longint u;
    span = longint'(1) <<< sndp_pkg::ExpBitsDef;
    u = v & (span - 1);
    if (v >= ExpLo && v <= ExpHi) return v;
    ps_wrap = 1'b1;
    if (u > ExpHi) return u - span;
    return u;
  endfunction

  // Append one fraction digit to the mantissa
  function automatic void mant_append(int dv);
    logic [63:0] lim;
    lim = (MantMask - 64'(dv)) / 64'd10;
    if (ps_mant > lim) ps_wrap = 1'b1;
    ps_mant = (ps_mant * 64'd10 + 64'(dv)) & MantMask;
  endfunction

  // Append one exponent digit to the 32-bit signed accumulator
  function automatic void exp_append(int dv);
    longint t;
    longint a;
    a = longint'(signed'(ps_exp_acc));
    t = a * 10 + longint'(dv);
    if (t > 64'sd2147483647 || t < -64'sd2147483648) ps_wrap = 1'b1;
    ps_exp_acc = t[31:0];
  endfunction

  // End the parse and settle status and exponent
  function automatic void parse_close();
    longint s;
    case (ps_phase)
      sndp_pkg::PhStart, sndp_pkg::PhAfterSign: ps_status = sndp_pkg::StatusNoLead;
      sndp_pkg::PhExpStart, sndp_pkg::PhExpAfterSign: ps_status = sndp_pkg::StatusNoExp;
      sndp_pkg::PhExpDigits: begin
        s = longint'(signed'(ps_exp_acc));
        ps_frac_exp = exp_fit(ps_frac_exp + (ps_exp_neg ? -s : s));
        ps_status = sndp_pkg::StatusOk;
      end
      default: ps_status = sndp_pkg::StatusOk;
    endcase
    ps_phase = sndp_pkg::PhDone;
  endfunction

  // Advance the parser by one character
  function automatic void parse_char(logic [sndp_pkg::CharW-1:0] c);
    bit dig;
    int dv;
    dig = (c >= sndp_pkg::CharZero && c <= sndp_pkg::CharNine);
    dv  = dig ? int'(c - sndp_pkg::CharZero) : 0;
    case (ps_phase)
      sndp_pkg::PhStart: begin
        if (c == sndp_pkg::CharMinus) begin
          ps_neg = 1'b1;
          ps_phase = sndp_pkg::PhAfterSign;
        end else if (c == sndp_pkg::CharPlus) begin
          ps_phase = sndp_pkg::PhAfterSign;
        end else if (dig) begin
          ps_mant = 64'(dv) & MantMask;
          ps_phase = sndp_pkg::PhAfterLead;
        end else parse_close();
      end
      sndp_pkg::PhAfterSign: begin
        if (dig) begin
          ps_mant = 64'(dv) & MantMask;
          ps_phase = sndp_pkg::PhAfterLead;
        end else parse_close();
      end
      sndp_pkg::PhAfterLead: begin
        if (c == sndp_pkg::CharDot) ps_phase = sndp_pkg::PhFraction;
        else if (c == sndp_pkg::CharE) ps_phase = sndp_pkg::PhExpStart;
        else parse_close();
      end
      sndp_pkg::PhFraction: begin
        if (dig) begin
          mant_append(dv);
          ps_frac_exp = exp_fit(ps_frac_exp - 1);
        end else if (c == sndp_pkg::CharE) ps_phase = sndp_pkg::PhExpStart;
        else parse_close();
      end
      sndp_pkg::PhExpStart: begin
        if (c == sndp_pkg::CharMinus) begin
          ps_exp_neg = 1'b1;
          ps_phase = sndp_pkg::PhExpAfterSign;
        end else if (c == sndp_pkg::CharPlus) begin
          ps_phase = sndp_pkg::PhExpAfterSign;
        end else if (dig) begin
          ps_exp_acc = 32'(dv);
          ps_phase = sndp_pkg::PhExpDigits;
        end else parse_close();
      end
      sndp_pkg::PhExpAfterSign: begin
        if (dig) begin
          ps_exp_acc = 32'(dv);
          ps_phase = sndp_pkg::PhExpDigits;
        end else parse_close();
      end
      sndp_pkg::PhExpDigits: begin
        if (dig) exp_append(dv);
        else parse_close();
      end
      default: ;
    endcase
  endfunction

  // Feed one accepted item; on the last character queue the parsed number
  function automatic void parse_item(logic [sndp_pkg::CharW-1:0] c, logic last);
    num_result_t r;
    parse_char(c);
    if (last) begin
      if (ps_phase != sndp_pkg::PhDone) parse_close();
      r.negative = ps_neg;
      r.status   = ps_status;
      if (ps_status == sndp_pkg::StatusNoLead) begin
        r.mantissa = '0;
        r.exponent = '0;
        r.overflow = 1'b0;
      end else begin
        r.mantissa = ps_mant;
        r.exponent = ps_frac_exp[sndp_pkg::ExpW-1:0];
        r.overflow = ps_wrap;
      end
      expected_numbers.push_back(r);
      parse_reset();
    end
  endfunction

  // Draw a wait length: none, full range, or mostly none
  function automatic int unsigned draw_wait(int mode);
    int unsigned w;
    case (mode)
      0: w = 0;
      1: w = $urandom_range(0, MaxWait);
      default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxWait) : 0;
    endcase
    return w;
  endfunction

  // Pick a character biased toward the grammar
  function automatic logic [sndp_pkg::CharW-1:0] noise_char();
    logic [sndp_pkg::CharW-1:0] c;
    case ($urandom_range(0, 7))
      0: c = sndp_pkg::CharZero + 8'($urandom_range(0, 9));
      1: c = sndp_pkg::CharDot;
      2: c = sndp_pkg::CharE;
      3: c = sndp_pkg::CharPlus;
      4: c = sndp_pkg::CharMinus;
      5: c = 8'h00;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  task automatic add_digits(int n);
    repeat (n) txt.push_back(sndp_pkg::CharZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic load_text(string s);
    txt.delete();
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  // Build a well-formed number with random content
  task automatic build_number();
    int k;
    int r;
    txt.delete();
    case ($urandom_range(0, 2))
      1: txt.push_back(sndp_pkg::CharMinus);
      2: txt.push_back(sndp_pkg::CharPlus);
      default: ;
    endcase
    add_digits(1);
    if ($urandom_range(0, 2) != 0) begin
      txt.push_back(sndp_pkg::CharDot);
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 26) : $urandom_range(0, 8);
      add_digits(k);
    end
    if ($urandom_range(0, 2) != 0) begin
      txt.push_back(sndp_pkg::CharE);
      case ($urandom_range(0, 2))
        1: txt.push_back(sndp_pkg::CharMinus);
        2: txt.push_back(sndp_pkg::CharPlus);
        default: ;
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) k = 0;
      else if (r < 3) k = $urandom_range(5, 12);
      else k = $urandom_range(1, 4);
      add_digits(k);
    end
    // trailing junk may extend the number, or is ignored once the parse ends
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) txt.push_back(noise_char());
  endtask

  // Break a well-formed number: overwrite, insert or truncate
  task automatic build_broken();
    int p;
    build_number();
    p = $urandom_range(0, txt.size() - 1);
    case ($urandom_range(0, 2))
      0: txt[p] = noise_char();
      1: txt.insert(p, noise_char());
      default: while (txt.size() > p + 1) void'(txt.pop_back());
    endcase
  endtask

  // Queue the built text, flagging its final character
  task automatic emit_text(bit drain);
    char_item_t it;
    foreach (txt[i]) begin
      it.code  = txt[i];
      it.last  = (i == txt.size() - 1);
      it.gap   = draw_wait(gap_mode);
      it.drain = drain && (i == 0);
      char_items.push_back(it);
    end
  endtask

  // Drive the input channel from the pending items
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (drv_active && in_taken) drv_active = 1'b0;
      if (!drv_active && char_items.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = char_items[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(char_items[0].drain && expected_numbers.size() != 0)) begin
          cur = char_items.pop_front();
          gap_armed  = 1'b0;
          drv_active = 1'b1;
        end
      end
      in_valid_i <= drv_active;
      if (drv_active) begin
        char_code_i <= cur.code;
        last_char_i <= cur.last;
      end else begin
        char_code_i <= 8'($urandom);
        last_char_i <= 1'($urandom);
      end
    end
  end

  // Hold the output stall while a result waits out its drawn count
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Predict on accepted characters, check accepted results
  always @(posedge clk_i) begin
    num_result_t want;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) parse_item(char_code_i, last_char_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_numbers.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: neg=%0b mant=%0h exp=%0d st=%0d ovf=%0b",
                   negative_o, mantissa_o, exponent_o, status_o, overflow_o);
      end else begin
        want = expected_numbers.pop_front();
        if (negative_o !== want.negative || mantissa_o !== want.mantissa ||
            exponent_o !== want.exponent || status_o !== want.status ||
            overflow_o !== want.overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"result mismatch: exp neg=%0b mant=%0h exp=%0d st=%0d ovf=%0b",
                      " | got neg=%0b mant=%0h exp=%0d st=%0d ovf=%0b"},
                     want.negative, want.mantissa, $signed(want.exponent), want.status,
                     want.overflow, negative_o, mantissa_o, exponent_o, status_o,
                     overflow_o);
        end
      end
      res_seen++;
      if (res_seen % 40 == 0) out_mode = $urandom_range(0, 2);
      stall_left = draw_wait(out_mode);
    end
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned n_chars;
    int unsigned n_strings;
    int pick;

    parse_reset();

    // Directed strings: sign only, bad first char, single digit, full form,
    // e without digits, e with sign only, exponent wrap, NUL terminator
    gap_mode = 1;
    load_text("-");       emit_text(1'b0);
    txt.delete(); txt.push_back(8'hff); emit_text(1'b0);
    load_text("0");       emit_text(1'b0);
    load_text("-9.5e-7"); emit_text(1'b0);
    load_text("1e");      emit_text(1'b0);
    load_text("2e+");     emit_text(1'b0);
    load_text("7e99999"); emit_text(1'b0);
    txt.delete();
    txt.push_back(sndp_pkg::CharZero + 8'd5);
    txt.push_back(8'h00);
    txt.push_back(sndp_pkg::CharZero + 8'd7);
    emit_text(1'b0);

    // Random strings, mostly well formed
    n_chars   = 0;
    n_strings = 0;
    while (n_chars < 1150) begin
      if (n_strings % 30 == 0) gap_mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_number();
      end else if (pick < 9) begin
        build_broken();
      end else begin
        txt.delete();
        repeat ($urandom_range(1, 5)) txt.push_back(noise_char());
      end
      n_chars += txt.size();
      emit_text(n_strings == 0 || $urandom_range(0, 39) == 0);
      n_strings++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain the stimulus and the outstanding results
    while (char_items.size() != 0 || drv_active) @(posedge clk_i);
    while (expected_numbers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatch_cnt += expected_numbers.size();
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
